/* src/nnld_pkg.sv */
// ----------------------------------------------------------------------------
// nnld_pkg
// Types, constants and helpers shared by the luma downscaler modules.
// ----------------------------------------------------------------------------
`default_nettype none

package nnld_pkg;

   localparam int DIM_W     = 13;
   localparam int POS_W     = 12;
   localparam int TW_W      = 14;
   localparam int PROD_W    = 25;
   localparam int CSR_IDX_W = 2;

   localparam logic [DIM_W-1:0] MAX_DIM   = 13'd4096;
   localparam logic [DIM_W-1:0] EVEN_MASK = ~13'd1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SOURCE_WIDTH  = 2'd0,
      CSR_SOURCE_HEIGHT = 2'd1,
      CSR_TARGET_WIDTH  = 2'd2,
      CSR_UNUSED        = 2'd3
   } nnld_csr_idx_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_MUL,
      S_DH_GO,
      S_DH_WAIT,
      S_CQ_GO,
      S_CQ_WAIT,
      S_RQ_GO,
      S_RQ_WAIT,
      S_STEP
   } nnld_state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } nnld_div_stat_type;

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
      logic [DIM_W-1:0] r;
      if (v == '0) begin
         r = DIM_W'(1);
      end else if (v > MAX_DIM) begin
         r = MAX_DIM;
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

/* src/nnld_divider.sv */
// ----------------------------------------------------------------------------
// nnld_divider
// Restoring radix-2 divider, one quotient bit per cycle, shared by the setup.
// ----------------------------------------------------------------------------
`default_nettype none

module nnld_divider #(
   parameter int NUM_W = 25,
   parameter int DEN_W = 13
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [NUM_W-1:0]            num,
   input  wire logic [DEN_W-1:0]            den,
   output      nnld_pkg::nnld_div_stat_type stat,
   output      logic [NUM_W-1:0]            quot,
   output      logic [DEN_W-1:0]            rem
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] q_ff, q_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DEN_W:0]   shifted;
   logic [DEN_W:0]   diff;
   logic             ge;

   always_comb begin
      shifted = {rem_ff, q_ff[NUM_W-1]};
      ge      = shifted >= {1'b0, den_ff};
      diff    = shifted - {1'b0, den_ff};
      q_in    = q_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         q_in    = num;
         rem_in  = '0;
         den_in  = den;
         cnt_in  = CNT_W'(NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         q_in   = {q_ff[NUM_W-2:0], ge};
         rem_in = ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      q_ff   <= q_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign stat = nnld_pkg::nnld_div_stat_type'({busy_ff, done_ff});
   assign quot = q_ff;
   assign rem  = rem_ff;

   a_no_restart : assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff) else $error("divider restarted while busy");
   a_done_pulse : assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff) else $error("divider done lasted two cycles");
   a_rem_below : assert property (@(posedge clock) disable iff (reset)
      done_ff |-> rem_ff < den_ff) else $error("remainder not below divisor");

endmodule

`default_nettype wire

/* src/nearest_neighbour_luma_downscaler.sv */
// ----------------------------------------------------------------------------
// nearest_neighbour_luma_downscaler
// Nearest-neighbor luma downscaler with per-frame division and DDA stepping.
// ----------------------------------------------------------------------------
// A word without frame_start is processed when accepted; its result appears next cycle.
// A word with frame_start is accepted, then the product is formed, then each of
// three 25-step divisions runs on the shared serial divider, and then the word is
// processed. A zero target width skips the divisions and a zero scaled height
// skips the last one. A waiting result holds off input.
// Reset is synchronous; no output until the first frame start.
`default_nettype none

module nearest_neighbour_luma_downscaler #(
   parameter int PIXEL_BITS = 8
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // tdata: luma_in
   input  wire logic [((PIXEL_BITS+7)/8)*8-1:0]     req_tdata,
   // tuser: frame_start
   input  wire logic                                req_tuser,
   input  wire logic                                req_tvalid,
   output      logic                                req_tready,
   // tdata: luma_out, scaled_width, scaled_height
   output      logic [((PIXEL_BITS+26+7)/8)*8-1:0]  rsp_tdata,
   // tuser: last_of_frame
   output      logic                                rsp_tuser,
   output      logic                                rsp_tlast,
   output      logic                                rsp_tvalid,
   input  wire logic                                rsp_tready,
   input  wire logic                                csr_we,
   input  wire logic [nnld_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [nnld_pkg::TW_W-1:0]           csr_wdata
);

   localparam int DW  = nnld_pkg::DIM_W;
   localparam int PW  = nnld_pkg::POS_W;
   localparam int RSP_W = ((PIXEL_BITS + 26 + 7) / 8) * 8;

   nnld_pkg::nnld_state_type state_ff, state_in;

   logic [DW-1:0] cfg_w_ff, cfg_h_ff;
   logic [nnld_pkg::TW_W-1:0] cfg_tw_ff;

   logic [PW-1:0] src_col_ff, src_col_in, src_row_ff, src_row_in;
   logic [DW-1:0] out_col_ff, out_col_in, out_row_ff, out_row_in;
   logic [DW-1:0] pick_col_ff, pick_col_in, col_rem_ff, col_rem_in;
   logic [DW-1:0] pick_row_ff, pick_row_in, row_rem_ff, row_rem_in;
   logic [DW-1:0] col_quot_ff, col_quot_in, col_srem_ff, col_srem_in;
   logic [DW-1:0] row_quot_ff, row_quot_in, row_srem_ff, row_srem_in;
   logic [DW-1:0] fow_ff, fow_in, foh_ff, foh_in;
   logic [DW-1:0] lat_w_ff, lat_w_in, lat_h_ff, lat_h_in;
   logic          started_ff, started_in;
   logic [nnld_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic [PIXEL_BITS-1:0] hold_luma_ff, hold_luma_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [PIXEL_BITS-1:0] rsp_luma_ff, rsp_luma_in;
   logic [DW-1:0]         rsp_sw_ff, rsp_sw_in, rsp_sh_ff, rsp_sh_in;
   logic                  rsp_last_ff, rsp_last_in, rsp_lof_ff, rsp_lof_in;

   logic                  div_start;
   logic [nnld_pkg::PROD_W-1:0] div_num, div_quot;
   logic [DW-1:0]         div_den, div_rem;
   nnld_pkg::nnld_div_stat_type div_stat;

   logic                  out_free, accept, step_en;
   logic [PIXEL_BITS-1:0] pix;
   logic [DW-1:0]         clw, clh, dw_new;
   logic                  row_hit, emit, line_end, lr;
   logic [DW:0]           col_sum, row_sum;
   logic                  col_wrap, row_wrap;
   logic [DW-1:0]         src_col_inc, src_row_inc;

   nnld_divider #(
      .NUM_W (nnld_pkg::PROD_W),
      .DEN_W (DW)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .stat  (div_stat),
      .quot  (div_quot),
      .rem   (div_rem)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_w_ff  <= DW'(640);
         cfg_h_ff  <= DW'(480);
         cfg_tw_ff <= '1;
      end else if (csr_we) begin
         unique case (nnld_pkg::nnld_csr_idx_type'(csr_index))
            nnld_pkg::CSR_SOURCE_WIDTH:  cfg_w_ff  <= csr_wdata[DW-1:0];
            nnld_pkg::CSR_SOURCE_HEIGHT: cfg_h_ff  <= csr_wdata[DW-1:0];
            nnld_pkg::CSR_TARGET_WIDTH:  cfg_tw_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      out_free   = !rsp_valid_ff || rsp_tready;
      req_tready = (state_ff == nnld_pkg::S_IDLE) && out_free;
      accept     = req_tvalid && req_tready;
      pix        = (state_ff == nnld_pkg::S_STEP) ? hold_luma_ff : req_tdata[PIXEL_BITS-1:0];
      step_en    = (accept && !req_tuser) || ((state_ff == nnld_pkg::S_STEP) && out_free);

      clw = nnld_pkg::clamp_dim(cfg_w_ff);
      clh = nnld_pkg::clamp_dim(cfg_h_ff);
      if (cfg_tw_ff[nnld_pkg::TW_W-1] || (cfg_tw_ff[DW-1:0] > clw)) begin
         dw_new = clw;
      end else begin
         dw_new = cfg_tw_ff[DW-1:0];
      end

      row_hit = (fow_ff != '0) && (foh_ff != '0) && (out_row_ff < foh_ff) &&
                ({1'b0, src_row_ff} == pick_row_ff);
      emit    = row_hit && (out_col_ff < fow_ff) && ({1'b0, src_col_ff} == pick_col_ff);
      lr      = out_col_ff == (fow_ff - DW'(1));
      col_sum = {1'b0, col_rem_ff} + {1'b0, col_srem_ff};
      col_wrap = col_sum >= {1'b0, fow_ff};
      row_sum = {1'b0, row_rem_ff} + {1'b0, row_srem_ff};
      row_wrap = row_sum >= {1'b0, foh_ff};
      src_col_inc = {1'b0, src_col_ff} + DW'(1);
      src_row_inc = {1'b0, src_row_ff} + DW'(1);
      line_end = src_col_inc >= lat_w_ff;

      state_in     = state_ff;
      src_col_in   = src_col_ff;
      src_row_in   = src_row_ff;
      out_col_in   = out_col_ff;
      out_row_in   = out_row_ff;
      pick_col_in  = pick_col_ff;
      col_rem_in   = col_rem_ff;
      pick_row_in  = pick_row_ff;
      row_rem_in   = row_rem_ff;
      col_quot_in  = col_quot_ff;
      col_srem_in  = col_srem_ff;
      row_quot_in  = row_quot_ff;
      row_srem_in  = row_srem_ff;
      fow_in       = fow_ff;
      foh_in       = foh_ff;
      lat_w_in     = lat_w_ff;
      lat_h_in     = lat_h_ff;
      started_in   = started_ff;
      prod_in      = prod_ff;
      hold_luma_in = hold_luma_ff;
      div_start    = 1'b0;
      div_num      = prod_ff;
      div_den      = lat_w_ff;

      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_luma_in  = rsp_luma_ff;
      rsp_sw_in    = rsp_sw_ff;
      rsp_sh_in    = rsp_sh_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_lof_in   = rsp_lof_ff;

      unique case (state_ff)
         nnld_pkg::S_IDLE: begin
            if (accept && req_tuser) begin
               hold_luma_in = req_tdata[PIXEL_BITS-1:0];
               lat_w_in     = clw;
               lat_h_in     = clh;
               started_in   = 1'b1;
               fow_in       = dw_new;
               foh_in       = '0;
               col_quot_in  = '0;
               col_srem_in  = '0;
               row_quot_in  = '0;
               row_srem_in  = '0;
               src_col_in   = '0;
               src_row_in   = '0;
               out_col_in   = '0;
               out_row_in   = '0;
               pick_col_in  = '0;
               col_rem_in   = '0;
               pick_row_in  = '0;
               row_rem_in   = '0;
               state_in     = (dw_new == '0) ? nnld_pkg::S_STEP : nnld_pkg::S_MUL;
            end
         end
         nnld_pkg::S_MUL: begin
            prod_in  = nnld_pkg::PROD_W'(lat_h_ff) * nnld_pkg::PROD_W'(fow_ff);
            state_in = nnld_pkg::S_DH_GO;
         end
         nnld_pkg::S_DH_GO: begin
            div_start = 1'b1;
            state_in  = nnld_pkg::S_DH_WAIT;
         end
         nnld_pkg::S_DH_WAIT: begin
            if (div_stat.done) begin
               foh_in   = div_quot[DW-1:0] & nnld_pkg::EVEN_MASK;
               state_in = nnld_pkg::S_CQ_GO;
            end
         end
         nnld_pkg::S_CQ_GO: begin
            div_start = 1'b1;
            div_num   = nnld_pkg::PROD_W'(lat_w_ff);
            div_den   = fow_ff;
            state_in  = nnld_pkg::S_CQ_WAIT;
         end
         nnld_pkg::S_CQ_WAIT: begin
            if (div_stat.done) begin
               col_quot_in = div_quot[DW-1:0];
               col_srem_in = div_rem;
               state_in    = (foh_ff == '0) ? nnld_pkg::S_STEP : nnld_pkg::S_RQ_GO;
            end
         end
         nnld_pkg::S_RQ_GO: begin
            div_start = 1'b1;
            div_num   = nnld_pkg::PROD_W'(lat_h_ff);
            div_den   = foh_ff;
            state_in  = nnld_pkg::S_RQ_WAIT;
         end
         nnld_pkg::S_RQ_WAIT: begin
            if (div_stat.done) begin
               row_quot_in = div_quot[DW-1:0];
               row_srem_in = div_rem;
               state_in    = nnld_pkg::S_STEP;
            end
         end
         nnld_pkg::S_STEP: begin
            if (out_free) begin
               state_in = nnld_pkg::S_IDLE;
            end
         end
         default: state_in = nnld_pkg::S_IDLE;
      endcase

      if (step_en) begin
         if (emit) begin
            rsp_valid_in = 1'b1;
            rsp_luma_in  = pix;
            rsp_last_in  = lr;
            rsp_lof_in   = lr && (out_row_ff == (foh_ff - DW'(1)));
            rsp_sw_in    = fow_ff;
            rsp_sh_in    = foh_ff;
            out_col_in   = out_col_ff + DW'(1);
            col_rem_in   = col_wrap ? DW'(col_sum - {1'b0, fow_ff}) : col_sum[DW-1:0];
            pick_col_in  = pick_col_ff + col_quot_ff + DW'(col_wrap);
         end
         if (started_ff) begin
            src_col_in = src_col_inc[PW-1:0];
            if (line_end) begin
               src_col_in = '0;
               if (row_hit) begin
                  out_row_in  = out_row_ff + DW'(1);
                  row_rem_in  = row_wrap ? DW'(row_sum - {1'b0, foh_ff}) : row_sum[DW-1:0];
                  pick_row_in = pick_row_ff + row_quot_ff + DW'(row_wrap);
               end
               out_col_in  = '0;
               pick_col_in = '0;
               col_rem_in  = '0;
               if (src_row_inc < lat_h_ff) begin
                  src_row_in = src_row_inc[PW-1:0];
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= nnld_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
         started_ff   <= 1'b0;
         src_col_ff   <= '0;
         src_row_ff   <= '0;
         out_col_ff   <= '0;
         out_row_ff   <= '0;
         pick_col_ff  <= '0;
         col_rem_ff   <= '0;
         pick_row_ff  <= '0;
         row_rem_ff   <= '0;
         col_quot_ff  <= '0;
         col_srem_ff  <= '0;
         row_quot_ff  <= '0;
         row_srem_ff  <= '0;
         fow_ff       <= '0;
         foh_ff       <= '0;
         lat_w_ff     <= '0;
         lat_h_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         started_ff   <= started_in;
         src_col_ff   <= src_col_in;
         src_row_ff   <= src_row_in;
         out_col_ff   <= out_col_in;
         out_row_ff   <= out_row_in;
         pick_col_ff  <= pick_col_in;
         col_rem_ff   <= col_rem_in;
         pick_row_ff  <= pick_row_in;
         row_rem_ff   <= row_rem_in;
         col_quot_ff  <= col_quot_in;
         col_srem_ff  <= col_srem_in;
         row_quot_ff  <= row_quot_in;
         row_srem_ff  <= row_srem_in;
         fow_ff       <= fow_in;
         foh_ff       <= foh_in;
         lat_w_ff     <= lat_w_in;
         lat_h_ff     <= lat_h_in;
      end
      prod_ff      <= prod_in;
      hold_luma_ff <= hold_luma_in;
      rsp_luma_ff  <= rsp_luma_in;
      rsp_sw_ff    <= rsp_sw_in;
      rsp_sh_ff    <= rsp_sh_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_lof_ff   <= rsp_lof_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_lof_ff;
   assign rsp_tdata  = RSP_W'({rsp_sh_ff, rsp_sw_ff, rsp_luma_ff});

   a_lof_is_last : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_lof_ff |-> rsp_last_ff) else $error("frame end without row end");
   a_col_bound : assert property (@(posedge clock) disable iff (reset)
      out_col_ff <= fow_ff) else $error("output column beyond scaled width");
   a_height_bound : assert property (@(posedge clock) disable iff (reset)
      foh_ff <= lat_h_ff) else $error("scaled height above source height");
   a_col_rem : assert property (@(posedge clock) disable iff (reset)
      fow_ff != '0 |-> col_rem_ff < fow_ff) else $error("column remainder out of range");
   a_no_drop : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_tready |=> rsp_valid_ff) else $error("result word dropped");

endmodule

`default_nettype wire
